// ----- sv/mqfp_pkg.sv -----
// Shared types and constants for the fixed-partition multi-queue block.
// Field widths, status and opcode codes, register indexes, FSM states.
// No dependencies.
`default_nettype none

package mqfp_pkg;

   localparam int DEF_STORE_DEPTH = 128;
   localparam int DEF_MAX_QUEUES  = 16;
   localparam int DEF_DATA_WIDTH  = 32;

   localparam int OP_W       = 1;
   localparam int QIDX_W     = 4;
   localparam int STATUS_W   = 2;
   localparam int NUMQ_W     = 5;
   localparam int QSIZE_W    = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [OP_W-1:0] OP_ENQ = 1'b0;
   localparam logic [OP_W-1:0] OP_DEQ = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_QUEUES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_SIZE = 1'd1;

   localparam logic [NUMQ_W-1:0]  NUMQ_RESET  = 5'd1;
   localparam logic [QSIZE_W-1:0] QSIZE_RESET = 8'd128;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PTR,
      ST_DATA
   } state_type;

endpackage

`default_nettype wire

// ----- sv/mqfp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the pointer memory and the queue store. No dependencies.
`default_nettype none

module mqfp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/multi_queue_fixed_partition.sv -----
// The pointer memory read is registered when an item is accepted, the store is read or
// written in ST_PTR, and ST_DATA loads the output register, waiting while a stalled
// earlier result holds it. One item is in flight at a time: the input stays stalled
// until the item has been loaded into the output register.
// Reset (synchronous): all queues empty, num_queues = 1, queue_size = 128; store
// contents stay undefined and need no clearing pass.
`default_nettype none

module multi_queue_fixed_partition
   import mqfp_pkg::*;
#(
   parameter int STORE_DEPTH = DEF_STORE_DEPTH,
   parameter int MAX_QUEUES  = DEF_MAX_QUEUES,
   parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic        [OP_W-1:0]       req_op,
   input  wire logic        [QIDX_W-1:0]     req_queue_index,
   input  wire logic signed [DATA_WIDTH-1:0] req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic             [STATUS_W-1:0]   rsp_status,
   output logic signed      [DATA_WIDTH-1:0] rsp_data,
   input  wire logic                         csr_write,
   input  wire logic        [CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [CSR_DATA_W-1:0] csr_data
);

   localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int PW  = AW;
   localparam int QW  = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
   localparam int SZW = $clog2(STORE_DEPTH + 1);
   localparam int MW  = AW + 5;

   // (q * size) mod STORE_DEPTH; q*size < 16*STORE_DEPTH, so four
   // conditional subtracts finish the reduction
   function automatic logic [AW-1:0] slice_base(input logic [QIDX_W-1:0] q,
                                                input logic [SZW-1:0]    size);
      logic [MW-1:0] acc;
      acc = MW'(q) * MW'(size);
      for (int k = 3; k >= 0; k--) begin
         if (acc >= (MW'(STORE_DEPTH) << k)) begin
            acc = acc - (MW'(STORE_DEPTH) << k);
         end
      end
      return acc[AW-1:0];
   endfunction

   state_type state_ff, state_in;

   logic [NUMQ_W-1:0]  num_queues_ff, num_queues_in;
   logic [QSIZE_W-1:0] queue_size_ff, queue_size_in;

   logic [OP_W-1:0]       op_ff, op_in;
   logic [QIDX_W-1:0]     q_ff, q_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [AW-1:0]         base_ff, base_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  deq_ok_ff, deq_ok_in;
   logic [MAX_QUEUES-1:0] not_empty_ff, not_empty_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic accept, in_ptr, in_data, out_free, load_out;

   logic [SZW-1:0]  size_eff;
   logic [QW-1:0]   q_addr;
   logic [2*PW-1:0] ptr_rdata, ptr_wdata;
   logic [PW-1:0]   head_rd, tail_rd, new_head, new_tail, offset;
   logic [SZW:0]    tail_next;
   logic            ne, new_ne, bad, full, enq_ok, deq_ok;
   logic [STATUS_W-1:0] res_status;
   logic [AW:0]     addr_sum;
   logic [AW-1:0]   store_addr;
   logic            ptr_wr_en, store_wr_en, store_rd_en;
   logic [DATA_WIDTH-1:0] store_rdata;

   // ---------------- FSM ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept)   state_in = ST_PTR;
         ST_PTR:                state_in = ST_DATA;
         ST_DATA: if (out_free) state_in = ST_IDLE;
         default:               state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      in_ptr    = 1'b0;
      in_data   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_stall = reset;
         ST_PTR:  in_ptr    = 1'b1;
         ST_DATA: in_data   = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_out = in_data && out_free;

   // ---------------- configuration ----------------
   always_comb begin
      num_queues_in = num_queues_ff;
      queue_size_in = queue_size_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_NUM_QUEUES: num_queues_in = csr_data[NUMQ_W-1:0];
            CSR_QUEUE_SIZE: queue_size_in = csr_data[QSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   assign size_eff = (32'(queue_size_ff) > STORE_DEPTH) ? SZW'(STORE_DEPTH)
                                                        : SZW'(queue_size_ff);

   // ---------------- item capture ----------------
   always_comb begin
      op_in    = op_ff;
      q_in     = q_ff;
      value_in = value_ff;
      base_in  = base_ff;
      if (accept) begin
         op_in    = req_op;
         q_in     = req_queue_index;
         value_in = req_value;
         base_in  = slice_base(req_queue_index, size_eff);
      end
   end

   // ---------------- pointer read-modify-write ----------------
   assign q_addr    = QW'(q_ff);
   assign head_rd   = ptr_rdata[2*PW-1:PW];
   assign tail_rd   = ptr_rdata[PW-1:0];
   assign ne        = not_empty_ff[q_addr];
   assign tail_next = (SZW+1)'(tail_rd) + (SZW+1)'(1);
   assign bad       = (NUMQ_W'(q_ff) >= num_queues_ff) || (32'(q_ff) >= MAX_QUEUES);
   assign full      = (size_eff == '0) || (ne && (tail_next >= (SZW+1)'(size_eff)));

   // pointers in memory are only meaningful while the queue is not empty
   always_comb begin
      res_status = STAT_OK;
      enq_ok     = 1'b0;
      deq_ok     = 1'b0;
      new_head   = head_rd;
      new_tail   = tail_rd;
      new_ne     = ne;
      offset     = tail_rd;
      if (bad) begin
         res_status = STAT_BAD_INDEX;
      end else if (op_ff == OP_ENQ) begin
         if (full) begin
            res_status = STAT_FULL;
         end else begin
            enq_ok = 1'b1;
            if (!ne) begin
               new_head = '0;
               new_tail = '0;
               new_ne   = 1'b1;
            end else begin
               new_tail = PW'(tail_next);
            end
            offset = new_tail;
         end
      end else begin
         if (!ne) begin
            res_status = STAT_EMPTY;
         end else begin
            deq_ok = 1'b1;
            offset = head_rd;
            if (head_rd == tail_rd) begin
               new_head = '0;
               new_tail = '0;
               new_ne   = 1'b0;
            end else begin
               new_head = head_rd + PW'(1);
            end
         end
      end
   end

   // base and offset are both below STORE_DEPTH
   assign addr_sum   = {1'b0, base_ff} + (AW+1)'(offset);
   assign store_addr = (addr_sum >= (AW+1)'(STORE_DEPTH))
                       ? AW'(addr_sum - (AW+1)'(STORE_DEPTH)) : AW'(addr_sum);

   assign ptr_wdata   = {new_head, new_tail};
   assign ptr_wr_en   = in_ptr && (enq_ok || deq_ok);
   assign store_wr_en = in_ptr && enq_ok;
   assign store_rd_en = in_ptr && deq_ok;

   always_comb begin
      not_empty_in = not_empty_ff;
      status_in    = status_ff;
      deq_ok_in    = deq_ok_ff;
      if (ptr_wr_en) begin
         not_empty_in[q_addr] = new_ne;
      end
      if (in_ptr) begin
         status_in = res_status;
         deq_ok_in = deq_ok;
      end
   end

   mqfp_ram #(
      .WIDTH (2*PW),
      .DEPTH (MAX_QUEUES)
   ) u_ptr_ram (
      .clock   (clock),
      .wr_en   (ptr_wr_en),
      .wr_addr (q_addr),
      .wr_data (ptr_wdata),
      .rd_en   (accept),
      .rd_addr (QW'(req_queue_index)),
      .rd_data (ptr_rdata)
   );

   mqfp_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_addr),
      .wr_data (value_ff),
      .rd_en   (store_rd_en),
      .rd_addr (store_addr),
      .rd_data (store_rdata)
   );

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in  = load_out || (rsp_valid_ff && rsp_stall);
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      if (load_out) begin
         rsp_status_in = status_ff;
         rsp_data_in   = deq_ok_ff ? store_rdata : '0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_queues_ff <= NUMQ_RESET;
         queue_size_ff <= QSIZE_RESET;
         not_empty_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_queues_ff <= num_queues_in;
         queue_size_ff <= queue_size_in;
         not_empty_ff  <= not_empty_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      q_ff          <= q_in;
      value_ff      <= value_in;
      base_ff       <= base_in;
      status_ff     <= status_in;
      deq_ok_ff     <= deq_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ----- sv/mqfp_checker.sv -----
// Port-level checks for the fixed-partition multi-queue block, bound to the top.
// Depends on mqfp_pkg and multi_queue_fixed_partition.
`default_nettype none

module mqfp_checker
   import mqfp_pkg::*;
#(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [STATUS_W-1:0]   rsp_status,
   input wire logic [DATA_WIDTH-1:0] rsp_data
);

   logic req_accept;
   assign req_accept = req_valid && !req_stall;

   // one item in flight: the input stays stalled while it is worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall ##1 req_stall)
      else $error("item accepted while previous item still in flight");

   // a fresh result traces back to an accepted item through ST_PTR and ST_DATA
   a_result_timing: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_accept, 3))
      else $error("result appeared without matching item");

   a_error_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_OK)) |-> (rsp_data == '0))
      else $error("nonzero data on failed request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind multi_queue_fixed_partition mqfp_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_mqfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_status (rsp_status),
   .rsp_data   (rsp_data)
);

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for multi_queue_fixed_partition.
// Carries its own model of the queues, drives random and directed requests
// through the valid/stall ports, and checks every result. Needs mqfp_pkg.
`timescale 1ns / 1ps

module tb;
   import mqfp_pkg::*;

   localparam int DW          = DEF_DATA_WIDTH;
   localparam int DEPTH       = DEF_STORE_DEPTH;
   localparam int MAXQ        = DEF_MAX_QUEUES;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE      = 8;
   localparam int PHASE_ITEMS = 125;
   localparam int NUM_PHASES  = 12;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [QIDX_W-1:0]   qidx;
      logic [DW-1:0]       value;
      logic [STATUS_W-1:0] status;
      logic [DW-1:0]       data;
   } queue_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid       = 1'b0;
   logic                   req_stall;
   logic [OP_W-1:0]        req_op          = OP_ENQ;
   logic [QIDX_W-1:0]      req_queue_index = '0;
   logic signed [DW-1:0]   req_value       = '0;
   logic                   rsp_valid;
   logic                   rsp_stall       = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic signed [DW-1:0]   rsp_data;
   logic                   csr_write       = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index       = CSR_NUM_QUEUES;
   logic [CSR_DATA_W-1:0]  csr_data        = '0;

   multi_queue_fixed_partition u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_queue_index (req_queue_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_data        (rsp_data),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model of the block's state
   int unsigned cfg_num_queues = 32'(NUMQ_RESET);
   int unsigned cfg_queue_size = 32'(QSIZE_RESET);
   int unsigned head_ptr [MAXQ];
   int unsigned tail_ptr [MAXQ];
   bit          occupied [MAXQ];
   logic [DW-1:0] store_word [DEPTH];
   bit          store_written [DEPTH];

   queue_cmd_type pending_cmds [$];
   queue_cmd_type awaited_rsp [$];
   queue_cmd_type bus_cmd;

   int cmds_planned = 0;
   int results_seen = 0;
   int fail_count = 0;
   int settings_run = 0;
   int status_seen [4] = '{0, 0, 0, 0};
   int quiet_cycles = 0;
   int send_gap = 0;
   int stall_left = 0;
   bit send_steady = 1'b0;
   bit recv_steady = 1'b0;

   function automatic int unsigned slice_len();
      return (cfg_queue_size > DEPTH) ? DEPTH : cfg_queue_size;
   endfunction

   function automatic int unsigned slot_addr(input int unsigned q, input int unsigned off);
      return (q * slice_len() + off) % DEPTH;
   endfunction

   // a dequeue must never land on a store entry that was never written
   function automatic bit dequeue_safe(input int unsigned q);
      if (q >= cfg_num_queues || !occupied[q])
         return 1'b1;
      return store_written[slot_addr(q, head_ptr[q])];
   endfunction

   // works out the result of one request, updates the model and queues the item
   function automatic void plan_cmd(input logic [OP_W-1:0] op, input int unsigned q,
                                    input logic [DW-1:0] value);
      queue_cmd_type c;
      int unsigned   addr;
      if (op == OP_DEQ && !dequeue_safe(q))
         op = OP_ENQ;
      c.op     = op;
      c.qidx   = q[QIDX_W-1:0];
      c.value  = value;
      c.status = STAT_OK;
      c.data   = '0;
      if (q >= cfg_num_queues) begin
         c.status = STAT_BAD_INDEX;
      end else if (op == OP_ENQ) begin
         if (slice_len() == 0 || (occupied[q] && tail_ptr[q] + 1 >= slice_len())) begin
            c.status = STAT_FULL;
         end else begin
            if (!occupied[q]) begin
               head_ptr[q] = 0;
               tail_ptr[q] = 0;
               occupied[q] = 1'b1;
            end else begin
               tail_ptr[q]++;
            end
            addr = slot_addr(q, tail_ptr[q]);
            store_word[addr]    = value;
            store_written[addr] = 1'b1;
         end
      end else if (!occupied[q]) begin
         c.status = STAT_EMPTY;
      end else begin
         c.data = store_word[slot_addr(q, head_ptr[q])];
         if (head_ptr[q] == tail_ptr[q]) begin
            head_ptr[q] = 0;
            tail_ptr[q] = 0;
            occupied[q] = 1'b0;
         end else begin
            head_ptr[q]++;
         end
      end
      pending_cmds.push_back(c);
      cmds_planned++;
   endfunction

   // mostly zero, sometimes short, now and then a long stretch
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic wait_drained();
      while (results_seen < cmds_planned)
         @(posedge clock);
   endtask

   task automatic quiesce();
      wait_drained();
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      if (idx == CSR_NUM_QUEUES)
         cfg_num_queues = 32'(val[NUMQ_W-1:0]);
      else
         cfg_queue_size = 32'(val[QSIZE_W-1:0]);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic random_phase(input int budget);
      int made;
      int span;
      int focus;
      int focus_hi;
      int mode;
      int unsigned q;
      logic [OP_W-1:0] op;
      made = 0;
      focus_hi = (cfg_num_queues > MAXQ) ? MAXQ : cfg_num_queues;
      while (made < budget) begin
         span  = $urandom_range(1, slice_len() + slice_len() / 4 + 3);
         if (span > budget - made)
            span = budget - made;
         focus = (focus_hi > 0) ? $urandom_range(0, focus_hi - 1) : $urandom_range(0, MAXQ - 1);
         mode  = $urandom_range(0, 2);
         repeat (span) begin
            q = ($urandom_range(0, 7) != 0) ? focus : $urandom_range(0, MAXQ - 1);
            case (mode)
               0: op = OP_ENQ;
               1: op = ($urandom_range(0, 9) != 0) ? OP_DEQ : OP_ENQ;
               default: op = OP_W'($urandom_range(0, 1));
            endcase
            plan_cmd(op, q, $urandom);
            made++;
         end
         if ($urandom_range(0, 9) == 0)
            wait_drained();
      end
      // empty every configured queue whose head entry is safe to dequeue, so the next setting starts from clean slices
      for (int unsigned d = 0; d < MAXQ; d++)
         while (d < cfg_num_queues && occupied[d] && dequeue_safe(d))
            plan_cmd(OP_DEQ, d, $urandom);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall)
            awaited_rsp.push_back(bus_cmd);
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               bus_cmd = pending_cmds.pop_front();
               req_op          <= bus_cmd.op;
               req_queue_index <= bus_cmd.qidx;
               req_value       <= bus_cmd.value;
               req_valid       <= 1'b1;
               send_gap        <= send_steady ? 0 : idle_span();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      queue_cmd_type e;
      int len;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (awaited_rsp.size() == 0) begin
               $error("result with none expected: status %0d data %0d", rsp_status, rsp_data);
               fail_count++;
            end else begin
               e = awaited_rsp.pop_front();
               status_seen[e.status]++;
               if (rsp_status !== e.status) begin
                  $error("status mismatch (op %0d queue %0d): expected %0d, actual %0d",
                         e.op, e.qidx, e.status, rsp_status);
                  fail_count++;
               end
               if (rsp_data !== e.data) begin
                  $error("data mismatch (op %0d queue %0d): expected %0d, actual %0d",
                         e.op, e.qidx, $signed(e.data), rsp_data);
                  fail_count++;
               end
            end
         end
         len = 0;
         if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            if (!recv_steady && $urandom_range(0, 3) == 0)
               len = idle_span();
            rsp_stall  <= (len != 0);
            stall_left <= (len != 0) ? len - 1 : 0;
         end
      end
   end

   // watchdog: too long without any item moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("multi_queue_fixed_partition verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned numq_plan [NUM_PHASES];
      int unsigned size_plan [NUM_PHASES];
      logic [CSR_DATA_W-1:0] numq_word;

      numq_plan = '{16, 4, 16, 8, 3, 16, 2, 31, 0, 5, 1, 16};
      size_plan = '{8, 32, 1, 0, 255, 16, 64, 7, 10, 3, 128, 2};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset setting: a single queue of 128 entries
      plan_cmd(OP_DEQ, 0, '0);
      plan_cmd(OP_ENQ, 1, 32'h7fff_ffff);
      plan_cmd(OP_DEQ, 15, 32'hffff_ffff);
      plan_cmd(OP_ENQ, 0, 32'h7fff_ffff);
      plan_cmd(OP_ENQ, 0, 32'h8000_0000);
      plan_cmd(OP_ENQ, 0, 32'h0000_0000);
      plan_cmd(OP_ENQ, 0, 32'hffff_ffff);
      plan_cmd(OP_ENQ, 0, 32'h5555_5555);
      plan_cmd(OP_ENQ, 0, 32'haaaa_aaaa);
      plan_cmd(OP_DEQ, 0, '0);
      plan_cmd(OP_DEQ, 0, 32'hffff_ffff);

      // shrink the slice under a live queue: its tail is past the new end
      quiesce();
      write_reg(CSR_QUEUE_SIZE, 8'd4);
      settings_run++;
      plan_cmd(OP_ENQ, 0, 32'h1234_5678);
      repeat (4) plan_cmd(OP_DEQ, 0, $urandom);
      plan_cmd(OP_DEQ, 0, $urandom);
      plan_cmd(OP_ENQ, 0, 32'hdead_beef);
      plan_cmd(OP_DEQ, 0, '0);

      // no queues at all: every index is bad
      quiesce();
      write_reg(CSR_NUM_QUEUES, 8'd0);
      settings_run++;
      plan_cmd(OP_ENQ, 0, 32'h0000_0001);
      plan_cmd(OP_DEQ, 0, '0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         quiesce();
         numq_word = CSR_DATA_W'($urandom);
         numq_word[NUMQ_W-1:0] = NUMQ_W'(numq_plan[p]);
         write_reg(CSR_NUM_QUEUES, numq_word);
         write_reg(CSR_QUEUE_SIZE, CSR_DATA_W'(size_plan[p]));
         settings_run++;
         send_steady = ($urandom_range(0, 3) == 0);
         recv_steady = ($urandom_range(0, 3) == 0);
         random_phase(PHASE_ITEMS);
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("%0d requests over %0d register settings", results_seen, settings_run);
      $display("results: ok %0d, full %0d, empty %0d, bad index %0d",
               status_seen[STAT_OK], status_seen[STAT_FULL],
               status_seen[STAT_EMPTY], status_seen[STAT_BAD_INDEX]);
      if (fail_count == 0)
         $display("multi_queue_fixed_partition verification clean");
      else
         $display("multi_queue_fixed_partition verification failed");
      $finish;
   end

endmodule
